// ===== sv/kqt_pkg.sv =====
// shared constants, types and command/status structs for the quantile threshold unit
package kqt_pkg;

  localparam int MAX_SAMPLES = 1024;
  localparam int MAX_GROUPS  = 32;
  localparam int SAMPLE_W    = 32;
  localparam int GC_W        = 6;
  localparam int NUM_W       = 5;
  localparam int ADDR_W      = $clog2(MAX_SAMPLES);
  localparam int CNT_W       = ADDR_W + 1;
  localparam int LANES       = MAX_GROUPS - 1;
  localparam int PROD_W      = CNT_W + NUM_W;
  localparam int STEP_W      = $clog2(PROD_W);
  localparam int BIT_W       = $clog2(SAMPLE_W);

  localparam logic [SAMPLE_W-1:0] SIGN_BIT = {1'b1, {(SAMPLE_W-1){1'b0}}};

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_RANK_INIT,
    ST_RANK_DIV,
    ST_RANK_SAVE,
    ST_SEL_READ,
    ST_SEL_DRAIN,
    ST_SEL_UPDATE,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic load;
    logic start;
    logic rank_init;
    logic div_step;
    logic rank_save;
    logic pass_read;
    logic pass_update;
    logic emit;
  } kqt_cmd_t;

  typedef struct packed {
    logic count_zero;
    logic div_last;
    logic rank_last;
    logic read_last;
    logic bit_last;
    logic emit_last;
    logic out_full;
  } kqt_stat_t;

endpackage

// ===== sv/kqt_ctrl.sv =====
// controller state machine sequencing load, rank division, bit passes and emission
module kqt_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              last_sample,
  input  kqt_pkg::kqt_stat_t stat,
  output logic              in_stall,
  output kqt_pkg::kqt_cmd_t cmd
);

  kqt_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= kqt_pkg::ST_LOAD;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      kqt_pkg::ST_LOAD: begin
        if (in_valid && last_sample) state_next = kqt_pkg::ST_RANK_INIT;
      end
      kqt_pkg::ST_RANK_INIT: begin
        if (stat.count_zero) state_next = kqt_pkg::ST_EMIT;
        else state_next = kqt_pkg::ST_RANK_DIV;
      end
      kqt_pkg::ST_RANK_DIV: begin
        if (stat.div_last) state_next = kqt_pkg::ST_RANK_SAVE;
      end
      kqt_pkg::ST_RANK_SAVE: begin
        if (stat.rank_last) state_next = kqt_pkg::ST_SEL_READ;
        else state_next = kqt_pkg::ST_RANK_INIT;
      end
      kqt_pkg::ST_SEL_READ: begin
        if (stat.read_last) state_next = kqt_pkg::ST_SEL_DRAIN;
      end
      kqt_pkg::ST_SEL_DRAIN: begin
        state_next = kqt_pkg::ST_SEL_UPDATE;
      end
      kqt_pkg::ST_SEL_UPDATE: begin
        if (stat.bit_last) state_next = kqt_pkg::ST_EMIT;
        else state_next = kqt_pkg::ST_SEL_READ;
      end
      kqt_pkg::ST_EMIT: begin
        if (!stat.out_full && stat.emit_last) state_next = kqt_pkg::ST_LOAD;
      end
      default: state_next = kqt_pkg::ST_LOAD;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    unique case (state)
      kqt_pkg::ST_LOAD: begin
        in_stall  = 1'b0;
        cmd.load  = in_valid;
        cmd.start = in_valid && last_sample;
      end
      kqt_pkg::ST_RANK_INIT:  cmd.rank_init   = !stat.count_zero;
      kqt_pkg::ST_RANK_DIV:   cmd.div_step    = 1'b1;
      kqt_pkg::ST_RANK_SAVE:  cmd.rank_save   = 1'b1;
      kqt_pkg::ST_SEL_READ:   cmd.pass_read   = 1'b1;
      kqt_pkg::ST_SEL_DRAIN:  cmd              = '0;
      kqt_pkg::ST_SEL_UPDATE: cmd.pass_update = 1'b1;
      kqt_pkg::ST_EMIT:       cmd.emit        = !stat.out_full;
      default:                cmd              = '0;
    endcase
  end

endmodule

// ===== sv/kqt_dpath.sv =====
// datapath: sample store, rank divider, per-threshold selection lanes and output register
module kqt_dpath (
  input  logic                              clk,
  input  logic                              rst,
  input  kqt_pkg::kqt_cmd_t                 cmd,
  output kqt_pkg::kqt_stat_t                stat,
  input  logic signed [kqt_pkg::SAMPLE_W-1:0] sample,
  input  logic                              cfg_valid,
  input  logic [kqt_pkg::GC_W-1:0]          group_count,
  input  logic                              out_stall,
  output logic                              out_valid,
  output logic signed [kqt_pkg::SAMPLE_W-1:0] threshold,
  output logic [kqt_pkg::NUM_W-1:0]         threshold_number,
  output logic                              last_threshold,
  output logic                              overflowed,
  output logic                              empty_set
);

  logic [kqt_pkg::SAMPLE_W-1:0] mem [kqt_pkg::MAX_SAMPLES];

  logic [kqt_pkg::GC_W-1:0]     group_reg;
  logic [kqt_pkg::GC_W-1:0]     k_eff;
  logic [kqt_pkg::GC_W-1:0]     k_m1;
  logic [kqt_pkg::CNT_W-1:0]    count;
  logic [kqt_pkg::CNT_W-1:0]    count_m1;
  logic                         overflow_flag;

  logic [kqt_pkg::NUM_W-1:0]    num;
  logic [kqt_pkg::NUM_W-1:0]    out_num;
  logic [kqt_pkg::PROD_W-1:0]   div_q;
  logic [kqt_pkg::GC_W-1:0]     rem;
  logic [kqt_pkg::GC_W:0]       rem_sh;
  logic                         div_bit;
  logic [kqt_pkg::STEP_W-1:0]   step;

  logic [kqt_pkg::ADDR_W-1:0]   addr;
  logic [kqt_pkg::BIT_W-1:0]    bit_idx;
  logic [kqt_pkg::SAMPLE_W-1:0] bit_sel;
  logic [kqt_pkg::SAMPLE_W-1:0] hi_mask;
  logic [kqt_pkg::SAMPLE_W-1:0] rd_data;
  logic [kqt_pkg::SAMPLE_W-1:0] key;
  logic                         rd_valid;

  logic [kqt_pkg::SAMPLE_W-1:0] lane_prefix [kqt_pkg::LANES];
  logic [kqt_pkg::CNT_W-1:0]    lane_rank   [kqt_pkg::LANES];
  logic [kqt_pkg::CNT_W-1:0]    lane_cnt    [kqt_pkg::LANES];
  logic [kqt_pkg::LANES-1:0]    lane_hit;

  // saturate group count into the supported range
  always_comb begin
    priority if (group_reg < kqt_pkg::GC_W'(2)) begin
      k_eff = kqt_pkg::GC_W'(2);
    end else if (group_reg > kqt_pkg::GC_W'(kqt_pkg::MAX_GROUPS)) begin
      k_eff = kqt_pkg::GC_W'(kqt_pkg::MAX_GROUPS);
    end else begin
      k_eff = group_reg;
    end
  end

  assign k_m1     = k_eff - kqt_pkg::GC_W'(1);
  assign count_m1 = count - kqt_pkg::CNT_W'(1);
  assign rem_sh   = {rem, div_q[kqt_pkg::PROD_W-1]};
  assign div_bit  = rem_sh >= {1'b0, k_eff};
  assign bit_sel  = kqt_pkg::SAMPLE_W'(1) << bit_idx;
  assign hi_mask  = ({kqt_pkg::SAMPLE_W{1'b1}} << bit_idx) << 1;
  assign key      = rd_data ^ kqt_pkg::SIGN_BIT;

  always_comb begin
    for (int l = 0; l < kqt_pkg::LANES; l++) begin
      lane_hit[l] = (((key ^ lane_prefix[l]) & hi_mask) == '0) && ((key & bit_sel) == '0);
    end
  end

  always_comb begin
    stat.count_zero = count == '0;
    stat.div_last   = step == kqt_pkg::STEP_W'(kqt_pkg::PROD_W - 1);
    stat.rank_last  = {1'b0, num} == k_m1;
    stat.read_last  = kqt_pkg::CNT_W'(addr) == count_m1;
    stat.bit_last   = bit_idx == '0;
    stat.emit_last  = {1'b0, out_num} == k_m1;
    stat.out_full   = out_valid && out_stall;
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      group_reg     <= kqt_pkg::GC_W'(2);
      count         <= '0;
      overflow_flag <= 1'b0;
      out_valid     <= 1'b0;
      rd_valid      <= 1'b0;
    end else begin
      if (cfg_valid) group_reg <= group_count;
      rd_valid <= cmd.pass_read;
      if (cmd.load) begin
        if (count < kqt_pkg::CNT_W'(kqt_pkg::MAX_SAMPLES)) count <= count + kqt_pkg::CNT_W'(1);
        else overflow_flag <= 1'b1;
      end else if (cmd.emit && stat.emit_last) begin
        count         <= '0;
        overflow_flag <= 1'b0;
      end
      if (cmd.emit) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
  end

  // sample store
  always_ff @(posedge clk) begin
    if (cmd.load && count < kqt_pkg::CNT_W'(kqt_pkg::MAX_SAMPLES)) begin
      mem[count[kqt_pkg::ADDR_W-1:0]] <= sample;
    end
    if (cmd.pass_read) rd_data <= mem[addr];
  end

  // rank divider and pass sequencing
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      num     <= kqt_pkg::NUM_W'(1);
      out_num <= kqt_pkg::NUM_W'(1);
      addr    <= '0;
      bit_idx <= kqt_pkg::BIT_W'(kqt_pkg::SAMPLE_W - 1);
    end
    if (cmd.rank_init) begin
      div_q <= kqt_pkg::PROD_W'(num) * kqt_pkg::PROD_W'(count);
      rem   <= '0;
      step  <= '0;
    end else if (cmd.div_step) begin
      div_q <= {div_q[kqt_pkg::PROD_W-2:0], div_bit};
      rem   <= div_bit ? kqt_pkg::GC_W'(rem_sh - {1'b0, k_eff}) : rem_sh[kqt_pkg::GC_W-1:0];
      step  <= step + kqt_pkg::STEP_W'(1);
    end
    if (cmd.rank_save) num <= num + kqt_pkg::NUM_W'(1);
    if (cmd.pass_read) begin
      addr <= stat.read_last ? '0 : addr + kqt_pkg::ADDR_W'(1);
    end
    if (cmd.pass_update) bit_idx <= bit_idx - kqt_pkg::BIT_W'(1);
    if (cmd.emit) out_num <= out_num + kqt_pkg::NUM_W'(1);
  end

  // selection lanes, one per threshold
  always_ff @(posedge clk) begin
    for (int l = 0; l < kqt_pkg::LANES; l++) begin
      if (cmd.start) begin
        lane_prefix[l] <= '0;
        lane_cnt[l]    <= '0;
      end else if (cmd.pass_update) begin
        if (lane_rank[l] >= lane_cnt[l]) begin
          lane_prefix[l] <= lane_prefix[l] | bit_sel;
          lane_rank[l]   <= lane_rank[l] - lane_cnt[l];
        end
        lane_cnt[l] <= '0;
      end else if (rd_valid && lane_hit[l]) begin
        lane_cnt[l] <= lane_cnt[l] + kqt_pkg::CNT_W'(1);
      end
      if (cmd.rank_save && kqt_pkg::NUM_W'(l) == num - kqt_pkg::NUM_W'(1)) begin
        lane_rank[l] <= div_q[kqt_pkg::CNT_W-1:0];
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      threshold        <= stat.count_zero ? '0
                          : (lane_prefix[out_num - kqt_pkg::NUM_W'(1)] ^ kqt_pkg::SIGN_BIT);
      threshold_number <= out_num;
      last_threshold   <= stat.emit_last;
      overflowed       <= overflow_flag;
      empty_set        <= stat.count_zero;
    end
  end

endmodule

// ===== sv/k_quantile_thresholds_unit.sv =====
// top level of the quantile threshold unit: controller plus datapath
//
// channel   direction  handshake               request contents
// in        input      in_valid / in_stall     sample, last_sample
// out       output     out_valid / out_stall   threshold, threshold_number, last_threshold,
//                                              overflowed, empty_set
// cfg       input      cfg_valid / cfg_ready   group_count
//
// samples load at one per cycle into a 1024-entry store
// after the last sample (unless the set is empty): rank division for the k-1 thresholds, then
// 32 bit passes over the store read port, then k-1 results, one per cycle when not stalled
// all k-1 thresholds are resolved together by parallel counting lanes
// rst is synchronous; it clears the sample count, overflow flag, state and group count (2)
// in_stall is high from the last sample until the final result is loaded into the output register
module k_quantile_thresholds_unit (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic signed [kqt_pkg::SAMPLE_W-1:0] sample,
  input  logic                              last_sample,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [kqt_pkg::SAMPLE_W-1:0] threshold,
  output logic [kqt_pkg::NUM_W-1:0]         threshold_number,
  output logic                              last_threshold,
  output logic                              overflowed,
  output logic                              empty_set,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [kqt_pkg::GC_W-1:0]          group_count
);

  kqt_pkg::kqt_cmd_t  cmd;
  kqt_pkg::kqt_stat_t stat;

  assign cfg_ready = 1'b1;

  kqt_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .last_sample (last_sample),
    .stat        (stat),
    .in_stall    (in_stall),
    .cmd         (cmd)
  );

  kqt_dpath u_dpath (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .stat             (stat),
    .sample           (sample),
    .cfg_valid        (cfg_valid),
    .group_count      (group_count),
    .out_stall        (out_stall),
    .out_valid        (out_valid),
    .threshold        (threshold),
    .threshold_number (threshold_number),
    .last_threshold   (last_threshold),
    .overflowed       (overflowed),
    .empty_set        (empty_set)
  );

endmodule

// ===== test/tb_top.sv =====
// testbench for k_quantile_thresholds_unit: directed table, then random sets
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [kqt_pkg::SAMPLE_W-1:0] value;
    logic [kqt_pkg::NUM_W-1:0]    number;
    logic                         final_one;
    logic                         dropped;
    logic                         no_samples;
  } threshold_t;

  typedef struct packed {
    logic                         set_groups;
    logic [kqt_pkg::GC_W-1:0]     groups;
    logic [kqt_pkg::SAMPLE_W-1:0] value;
    logic                         last;
    logic                         typed;
    logic [kqt_pkg::SAMPLE_W-1:0] typed_thr;
  } stim_row_t;

  typedef enum logic [1:0] {STALL_NONE, STALL_COIN, STALL_HEAVY} stall_mode_t;

  localparam int ROWS = 21;
  localparam int MAX_MISMATCH_PRINTS = 10;

  // single-sample sets at two groups carry their expected threshold in the table
  localparam stim_row_t DIR_ROWS [0:ROWS-1] = '{
    '{1'b0, 6'd0,  32'h7FFF_FFFF, 1'b1, 1'b1, 32'h7FFF_FFFF},
    '{1'b0, 6'd0,  32'h8000_0000, 1'b1, 1'b1, 32'h8000_0000},
    '{1'b0, 6'd0,  32'h0000_0000, 1'b1, 1'b1, 32'h0000_0000},
    '{1'b0, 6'd0,  32'hFFFF_FFFF, 1'b1, 1'b1, 32'hFFFF_FFFF},
    '{1'b1, 6'd0,  32'h1234_5678, 1'b1, 1'b1, 32'h1234_5678},
    '{1'b1, 6'd63, 32'h0000_0005, 1'b0, 1'b0, 32'h0},
    '{1'b0, 6'd0,  32'h8000_0000, 1'b0, 1'b0, 32'h0},
    '{1'b0, 6'd0,  32'h7FFF_FFFF, 1'b1, 1'b0, 32'h0},
    '{1'b1, 6'd1,  32'hFFFF_FFFF, 1'b0, 1'b0, 32'h0},
    '{1'b0, 6'd0,  32'h0000_0000, 1'b0, 1'b0, 32'h0},
    '{1'b0, 6'd0,  32'h0000_0001, 1'b0, 1'b0, 32'h0},
    '{1'b0, 6'd0,  32'h8000_0000, 1'b1, 1'b0, 32'h0},
    '{1'b1, 6'd32, 32'h0000_0007, 1'b0, 1'b0, 32'h0},
    '{1'b0, 6'd0,  32'h0000_0007, 1'b0, 1'b0, 32'h0},
    '{1'b0, 6'd0,  32'hFFFF_FFF9, 1'b0, 1'b0, 32'h0},
    '{1'b0, 6'd0,  32'h0000_0007, 1'b0, 1'b0, 32'h0},
    '{1'b0, 6'd0,  32'hFFFF_FFF9, 1'b1, 1'b0, 32'h0},
    '{1'b1, 6'd33, 32'hAAAA_AAAA, 1'b1, 1'b0, 32'h0},
    '{1'b1, 6'd3,  32'h5555_5555, 1'b0, 1'b0, 32'h0},
    '{1'b0, 6'd0,  32'hAAAA_AAAA, 1'b0, 1'b0, 32'h0},
    '{1'b0, 6'd0,  32'h0000_0000, 1'b1, 1'b0, 32'h0}
  };

  logic                         clk = 1'b0;
  logic                         rst = 1'b1;
  logic                         in_valid = 1'b0;
  logic                         in_stall;
  logic [kqt_pkg::SAMPLE_W-1:0] sample = '0;
  logic                         last_sample = 1'b0;
  logic                         out_valid;
  logic                         out_stall = 1'b0;
  logic [kqt_pkg::SAMPLE_W-1:0] threshold;
  logic [kqt_pkg::NUM_W-1:0]    threshold_number;
  logic                         last_threshold;
  logic                         overflowed;
  logic                         empty_set;
  logic                         cfg_valid = 1'b0;
  logic                         cfg_ready;
  logic [kqt_pkg::GC_W-1:0]     group_count = '0;

  k_quantile_thresholds_unit u_top (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .sample           (sample),
    .last_sample      (last_sample),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .threshold        (threshold),
    .threshold_number (threshold_number),
    .last_threshold   (last_threshold),
    .overflowed       (overflowed),
    .empty_set        (empty_set),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .group_count      (group_count)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state
  logic signed [kqt_pkg::SAMPLE_W-1:0] held_samples [kqt_pkg::MAX_SAMPLES];
  int                                  held_count = 0;
  logic                                held_overflow = 1'b0;
  logic [kqt_pkg::GC_W-1:0]            groups_setting = 6'd2;
  threshold_t                          pending_thresholds [$];

  int          mismatches = 0;
  int          burst_left = 0;
  stall_mode_t stall_mode = STALL_NONE;
  int          stall_mode_left = 0;
  threshold_t  got;
  threshold_t  want;

  function automatic int effective_groups();
    if (groups_setting < 2) return 2;
    if (groups_setting > kqt_pkg::MAX_GROUPS) return kqt_pkg::MAX_GROUPS;
    return int'(groups_setting);
  endfunction

  function automatic void sort_held(input int n);
    logic signed [kqt_pkg::SAMPLE_W-1:0] v;
    int j;
    for (int i = 1; i < n; i++) begin
      v = held_samples[i];
      j = i - 1;
      while (j >= 0 && held_samples[j] > v) begin
        held_samples[j + 1] = held_samples[j];
        j--;
      end
      held_samples[j + 1] = v;
    end
  endfunction

  // takes one accepted request; on the last of a set, queues k-1 thresholds
  function automatic void absorb_sample(input logic [kqt_pkg::SAMPLE_W-1:0] v, input logic l,
                                        input logic typed,
                                        input logic [kqt_pkg::SAMPLE_W-1:0] typed_thr);
    int k;
    int n;
    int rank;
    threshold_t r;
    if (held_count < kqt_pkg::MAX_SAMPLES) begin
      held_samples[held_count] = v;
      held_count++;
    end else begin
      held_overflow = 1'b1;
    end
    if (!l) return;
    k = effective_groups();
    n = held_count;
    sort_held(n);
    for (int i = 1; i < k; i++) begin
      rank = (i * n) / k;
      if (rank >= n) rank = n - 1;
      r.value = (n == 0) ? '0 : (typed ? typed_thr : held_samples[rank]);
      r.number = kqt_pkg::NUM_W'(i);
      r.final_one = (i == k - 1);
      r.dropped = held_overflow;
      r.no_samples = (n == 0);
      pending_thresholds.push_back(r);
    end
    held_count = 0;
    held_overflow = 1'b0;
  endfunction

  function automatic void check_field(input string name,
                                      input logic [kqt_pkg::SAMPLE_W-1:0] e,
                                      input logic [kqt_pkg::SAMPLE_W-1:0] a);
    if (a !== e) begin
      mismatches++;
      if (mismatches <= MAX_MISMATCH_PRINTS)
        $display("mismatch on %s: expected %h, got %h", name, e, a);
    end
  endfunction

  function automatic logic [kqt_pkg::SAMPLE_W-1:0] rand_sample();
    int t;
    unique case ($urandom_range(0, 9))
      0, 1, 2: return $urandom;
      3, 4, 5: begin
        t = int'($urandom_range(0, 20)) - 10;
        return t;
      end
      6: return 32'h8000_0000 + $urandom_range(0, 3);
      7: return 32'h7FFF_FFFF - $urandom_range(0, 3);
      default: begin
        unique case ($urandom_range(0, 3))
          0: return 32'h8000_0000;
          1: return 32'h7FFF_FFFF;
          2: return 32'hFFFF_FFFF;
          default: return 32'h0;
        endcase
      end
    endcase
  endfunction

  function automatic logic [kqt_pkg::GC_W-1:0] pick_groups();
    unique case ($urandom_range(0, 9))
      0: return 6'd0;
      1: return 6'd1;
      2: return 6'd2;
      3: return 6'd32;
      4: return 6'd33;
      5: return 6'd63;
      default: return kqt_pkg::GC_W'($urandom_range(2, 32));
    endcase
  endfunction

  task automatic send_sample(input logic [kqt_pkg::SAMPLE_W-1:0] v, input logic l,
                             input logic typed, input logic [kqt_pkg::SAMPLE_W-1:0] typed_thr);
    int gap;
    in_valid <= 1'b1;
    sample <= v;
    last_sample <= l;
    do @(posedge clk); while (in_stall);
    absorb_sample(v, l, typed, typed_thr);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = $urandom_range(1, 6);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 8);
    end
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_thresholds.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_groups(input logic [kqt_pkg::GC_W-1:0] v);
    cfg_valid <= 1'b1;
    group_count <= v;
    do @(posedge clk); while (!cfg_ready);
    groups_setting = v;
    cfg_valid <= 1'b0;
  endtask

  task automatic send_random_set(input int len);
    for (int i = 1; i <= len; i++)
      send_sample(rand_sample(), i == len, 1'b0, '0);
  endtask

  // result checker and receiver stall pattern
  always @(posedge clk) begin
    if (rst == 1'b0 && out_valid === 1'b1 && out_stall == 1'b0) begin
      got = '{threshold, threshold_number, last_threshold, overflowed, empty_set};
      if (pending_thresholds.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_MISMATCH_PRINTS)
          $display("unexpected result: threshold %h number %0d", threshold, threshold_number);
      end else begin
        want = pending_thresholds.pop_front();
        check_field("threshold", want.value, got.value);
        check_field("threshold_number", 32'(want.number), 32'(got.number));
        check_field("last_threshold", 32'(want.final_one), 32'(got.final_one));
        check_field("overflowed", 32'(want.dropped), 32'(got.dropped));
        check_field("empty_set", 32'(want.no_samples), 32'(got.no_samples));
      end
    end
    if (stall_mode_left == 0) begin
      stall_mode = stall_mode_t'($urandom_range(0, 2));
      stall_mode_left = $urandom_range(16, 200);
    end else begin
      stall_mode_left--;
    end
    unique case (stall_mode)
      STALL_COIN:  out_stall <= 1'($urandom_range(0, 1));
      STALL_HEAVY: out_stall <= ($urandom_range(0, 7) != 0);
      default:     out_stall <= 1'b0;
    endcase
  end

  initial begin
    int sent;
    int len;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int r = 0; r < ROWS; r++) begin
      if (DIR_ROWS[r].set_groups) begin
        wait_idle();
        write_groups(DIR_ROWS[r].groups);
      end
      send_sample(DIR_ROWS[r].value, DIR_ROWS[r].last, DIR_ROWS[r].typed,
                  DIR_ROWS[r].typed_thr);
    end

    sent = 0;
    while (sent < 160) begin
      if ($urandom_range(0, 2) == 0) begin
        wait_idle();
        write_groups(pick_groups());
      end
      len = ($urandom_range(0, 5) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
      send_random_set(len);
      sent += len;
    end

    wait_idle();
    repeat (20) @(posedge clk);
    if (mismatches == 0 && pending_thresholds.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
